[hw/rtl/prc_pkg.sv]
// Package for the pulse range calibrator: widths, action codes and the
// per-channel state record. Used by prc_chan_update and the top level.
package prc_pkg;

  localparam int NUM_CHANNELS = 2;
  localparam int CH_W         = 1;
  localparam int PW_W         = 16;

  localparam logic [PW_W-1:0] DEADBAND_RESET = 16'd50;

  localparam logic ACT_START  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  typedef struct packed {
    logic            in_prog;
    logic            first;
    logic [PW_W-1:0] wmin;
    logic [PW_W-1:0] wmid;
    logic [PW_W-1:0] wmax;
    logic [PW_W-1:0] smin;
    logic [PW_W-1:0] smid;
    logic [PW_W-1:0] smax;
  } chan_state_t;

  typedef struct packed {
    logic start_acc;
    logic done;
  } step_flags_t;

endpackage

[hw/rtl/pulse_range_calibrator_top.sv]
// Top level of the pulse range calibrator: input register, channel update
// and result register. Depends on prc_pkg and prc_chan_update.

// Each transfer on the input channel names a channel and either starts
// calibration (pulse nonzero arms it) or presents one pulse sample; exactly
// one result follows per item. The block takes one item per cycle unless the
// output stalls: an item waits in the input register, then the per-channel
// state is read and rewritten as the item moves into the result register,
// so back-to-back items on the same channel see each other's updates.
// in_ready drops only while both registers are full and out_ready is low.
// The deadband register resets to 50 and is written through the cfg
// channel, which is always ready; write it only while idle.
module pulse_range_calibrator_top (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [prc_pkg::PW_W-1:0] cfg_deadband,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_action,
  input  logic [prc_pkg::CH_W-1:0] in_channel,
  input  logic [prc_pkg::PW_W-1:0] in_pulse_width,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_start_accepted,
  output logic                     out_busy_res,
  output logic                     out_finished_now,
  output logic [prc_pkg::PW_W-1:0] out_stored_min,
  output logic [prc_pkg::PW_W-1:0] out_stored_mid,
  output logic [prc_pkg::PW_W-1:0] out_stored_max
);

  logic [prc_pkg::PW_W-1:0] deadband_r;

  logic                     s1_valid_r;
  logic                     s1_action_r;
  logic [prc_pkg::CH_W-1:0] s1_channel_r;
  logic [prc_pkg::PW_W-1:0] s1_pulse_r;

  prc_pkg::chan_state_t     chan_r [prc_pkg::NUM_CHANNELS];
  prc_pkg::chan_state_t     cur;
  prc_pkg::chan_state_t     chan_nxt;
  prc_pkg::step_flags_t     flags;

  logic                     out_valid_r;
  logic                     out_start_r;
  logic                     out_busy_r;
  logic                     out_done_r;
  logic [prc_pkg::PW_W-1:0] out_min_r;
  logic [prc_pkg::PW_W-1:0] out_mid_r;
  logic [prc_pkg::PW_W-1:0] out_max_r;

  logic                     advance;
  logic                     ch_ok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r <= prc_pkg::DEADBAND_RESET;
    end else if (cfg_valid && cfg_ready) begin
      deadband_r <= cfg_deadband;
    end
  end

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_action_r  <= in_action;
      s1_channel_r <= in_channel;
      s1_pulse_r   <= in_pulse_width;
    end
  end

  assign ch_ok = (int'(s1_channel_r) < prc_pkg::NUM_CHANNELS);
  assign cur   = ch_ok ? chan_r[s1_channel_r] : '0;

  prc_chan_update u_update (
    .cur      (cur),
    .action   (s1_action_r),
    .pulse    (s1_pulse_r),
    .deadband (deadband_r),
    .nxt      (chan_nxt),
    .flags    (flags)
  );

  // commit channel state as the item moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < prc_pkg::NUM_CHANNELS; i++) begin
        chan_r[i] <= '0;
      end
    end else if (s1_valid_r && advance && ch_ok) begin
      chan_r[s1_channel_r] <= chan_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_start_r <= ch_ok && flags.start_acc;
      out_busy_r  <= ch_ok && chan_nxt.in_prog;
      out_done_r  <= ch_ok && flags.done;
      out_min_r   <= ch_ok ? chan_nxt.smin : '0;
      out_mid_r   <= ch_ok ? chan_nxt.smid : '0;
      out_max_r   <= ch_ok ? chan_nxt.smax : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_start_accepted = out_start_r;
  assign out_busy_res       = out_busy_r;
  assign out_finished_now   = out_done_r;
  assign out_stored_min     = out_min_r;
  assign out_stored_mid     = out_mid_r;
  assign out_stored_max     = out_max_r;

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> !out_busy_r)
    else $error("finished item still reports busy");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_start_r |-> out_busy_r)
    else $error("accepted start left channel idle");

  a_done_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> (out_min_r < out_mid_r) && (out_mid_r < out_max_r))
    else $error("stored calibration not ordered min < mid < max");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ready)
    else $error("input stalled without a full pipeline");

endmodule

[hw/rtl/prc_chan_update.sv]
// Next-state logic for one channel's calibration record.
// Depends on prc_pkg for the state record and action codes.
module prc_chan_update (
  input  prc_pkg::chan_state_t     cur,
  input  logic                     action,
  input  logic [prc_pkg::PW_W-1:0] pulse,
  input  logic [prc_pkg::PW_W-1:0] deadband,
  output prc_pkg::chan_state_t     nxt,
  output prc_pkg::step_flags_t     flags
);

  // 18-bit signed copies so mid +/- deadband never overflows
  logic signed [prc_pkg::PW_W+1:0] p_s;
  logic signed [prc_pkg::PW_W+1:0] mid_s;
  logic signed [prc_pkg::PW_W+1:0] db_s;
  logic signed [prc_pkg::PW_W+1:0] upper_s;
  logic signed [prc_pkg::PW_W+1:0] lower_s;
  logic                            above;
  logic                            below;
  logic                            near_mid;
  logic [prc_pkg::PW_W-1:0]        new_min;
  logic [prc_pkg::PW_W-1:0]        new_max;

  assign p_s     = signed'({2'b00, pulse});
  assign mid_s   = signed'({2'b00, cur.wmid});
  assign db_s    = signed'({2'b00, deadband});
  assign upper_s = mid_s + db_s;
  assign lower_s = mid_s - db_s;

  assign above    = (p_s > upper_s) && (pulse > cur.wmax);
  assign below    = (p_s < lower_s) && (pulse < cur.wmin);
  assign near_mid = (p_s < upper_s) && (p_s > lower_s);
  assign new_max  = above ? pulse : cur.wmax;
  assign new_min  = below ? pulse : cur.wmin;

  always_comb begin
    nxt   = cur;
    flags = '0;
    case (action)
      prc_pkg::ACT_START: begin
        if (pulse != '0) begin
          nxt.in_prog     = 1'b1;
          nxt.first       = 1'b1;
          flags.start_acc = 1'b1;
        end
      end
      prc_pkg::ACT_SAMPLE: begin
        if (cur.in_prog) begin
          if (cur.first) begin
            nxt.wmin  = pulse;
            nxt.wmid  = pulse;
            nxt.wmax  = pulse;
            nxt.first = 1'b0;
          end else begin
            nxt.wmin = new_min;
            nxt.wmax = new_max;
            // both extremes seen and back near center: store and finish
            if ((new_min < cur.wmid) && (new_max > cur.wmid) && near_mid) begin
              nxt.smin    = new_min;
              nxt.smid    = cur.wmid;
              nxt.smax    = new_max;
              nxt.in_prog = 1'b0;
              flags.done  = 1'b1;
            end
          end
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

[test/prc_calib_checker.sv]
// Checker for the pulse range calibrator: watches the cfg, input and result
// channels, predicts each result from the accepted items, and compares.
// Depends on prc_pkg for widths and action codes.
module prc_calib_checker (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [prc_pkg::PW_W-1:0] cfg_deadband,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic                     in_action,
  input  logic [prc_pkg::CH_W-1:0] in_channel,
  input  logic [prc_pkg::PW_W-1:0] in_pulse_width,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic                     out_start_accepted,
  input  logic                     out_busy_res,
  input  logic                     out_finished_now,
  input  logic [prc_pkg::PW_W-1:0] out_stored_min,
  input  logic [prc_pkg::PW_W-1:0] out_stored_mid,
  input  logic [prc_pkg::PW_W-1:0] out_stored_max,
  output int                       fail_count,
  output int                       pending
);

  typedef struct packed {
    logic                     start_acc;
    logic                     busy;
    logic                     fin;
    logic [prc_pkg::PW_W-1:0] smin;
    logic [prc_pkg::PW_W-1:0] smid;
    logic [prc_pkg::PW_W-1:0] smax;
  } cal_result_t;

  // Shadow of the block's per-channel state and its deadband register.
  logic [prc_pkg::PW_W-1:0] deadband_q;
  logic                     armed   [prc_pkg::NUM_CHANNELS];
  logic                     fresh   [prc_pkg::NUM_CHANNELS];
  logic [prc_pkg::PW_W-1:0] run_lo  [prc_pkg::NUM_CHANNELS];
  logic [prc_pkg::PW_W-1:0] run_mid [prc_pkg::NUM_CHANNELS];
  logic [prc_pkg::PW_W-1:0] run_hi  [prc_pkg::NUM_CHANNELS];
  logic [prc_pkg::PW_W-1:0] cal_lo  [prc_pkg::NUM_CHANNELS];
  logic [prc_pkg::PW_W-1:0] cal_mid [prc_pkg::NUM_CHANNELS];
  logic [prc_pkg::PW_W-1:0] cal_hi  [prc_pkg::NUM_CHANNELS];

  cal_result_t expected_calib[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic calibrate_step(input logic act, input logic [prc_pkg::CH_W-1:0] ch,
                                input logic [prc_pkg::PW_W-1:0] pw,
                                output cal_result_t r);
    int p, m, d, lo, hi, gap;
    r = '0;
    if (int'(ch) >= prc_pkg::NUM_CHANNELS) return;
    if (act == prc_pkg::ACT_START) begin
      if (pw != '0) begin
        armed[ch]   = 1'b1;
        fresh[ch]   = 1'b1;
        r.start_acc = 1'b1;
      end
    end else if (armed[ch]) begin
      if (fresh[ch]) begin
        run_lo[ch]  = pw;
        run_mid[ch] = pw;
        run_hi[ch]  = pw;
        fresh[ch]   = 1'b0;
      end else begin
        // signed 32-bit math: mid - deadband may go negative
        p  = int'(pw);
        m  = int'(run_mid[ch]);
        d  = int'(deadband_q);
        lo = int'(run_lo[ch]);
        hi = int'(run_hi[ch]);
        if (p > m + d && p > hi) begin
          run_hi[ch] = pw;
          hi = p;
        end
        if (p < m - d && p < lo) begin
          run_lo[ch] = pw;
          lo = p;
        end
        gap = (m > p) ? m - p : p - m;
        if (lo < m && hi > m && gap < d) begin
          cal_lo[ch]  = run_lo[ch];
          cal_mid[ch] = run_mid[ch];
          cal_hi[ch]  = run_hi[ch];
          armed[ch]   = 1'b0;
          r.fin       = 1'b1;
        end
      end
    end
    r.busy = armed[ch];
    r.smin = cal_lo[ch];
    r.smid = cal_mid[ch];
    r.smax = cal_hi[ch];
  endtask

  task automatic check_field(input string name, input logic [prc_pkg::PW_W-1:0] want,
                             input logic [prc_pkg::PW_W-1:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    cal_result_t want;
    int i;
    if (!rst_n) begin
      deadband_q = prc_pkg::DEADBAND_RESET;
      for (i = 0; i < prc_pkg::NUM_CHANNELS; i++) begin
        armed[i]   = 1'b0;
        fresh[i]   = 1'b0;
        run_lo[i]  = '0;
        run_mid[i] = '0;
        run_hi[i]  = '0;
        cal_lo[i]  = '0;
        cal_mid[i] = '0;
        cal_hi[i]  = '0;
      end
      expected_calib.delete();
    end else begin
      if (cfg_valid && cfg_ready) deadband_q = cfg_deadband;
      // retire the result first: it always belongs to an older item
      if (out_valid && out_ready) begin
        if (expected_calib.size() == 0) begin
          fail_count++;
          $display("%0t: result transfer, expected none, actual min %0d mid %0d max %0d",
                   $time, out_stored_min, out_stored_mid, out_stored_max);
        end else begin
          want = expected_calib.pop_front();
          check_field("start_accepted", prc_pkg::PW_W'(want.start_acc),
                      prc_pkg::PW_W'(out_start_accepted));
          check_field("busy_res", prc_pkg::PW_W'(want.busy), prc_pkg::PW_W'(out_busy_res));
          check_field("finished_now", prc_pkg::PW_W'(want.fin),
                      prc_pkg::PW_W'(out_finished_now));
          check_field("stored_min", want.smin, out_stored_min);
          check_field("stored_mid", want.smid, out_stored_mid);
          check_field("stored_max", want.smax, out_stored_max);
        end
      end
      if (in_valid && in_ready) begin
        calibrate_step(in_action, in_channel, in_pulse_width, want);
        expected_calib.push_back(want);
      end
    end
    pending = expected_calib.size();
  end

endmodule

[test/pulse_range_calibrator_top_tb.sv]
// Testbench top for the pulse range calibrator: clock, reset, stimulus with
// bursty input and stalling output, deadband phases and the final verdict.
// Depends on prc_pkg, pulse_range_calibrator_top and prc_calib_checker.
module pulse_range_calibrator_top_tb;

  localparam int PW_MAX      = (1 << prc_pkg::PW_W) - 1;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_ITEMS = 70;

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [prc_pkg::PW_W-1:0] cfg_deadband = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     in_action = prc_pkg::ACT_START;
  logic [prc_pkg::CH_W-1:0] in_channel = '0;
  logic [prc_pkg::PW_W-1:0] in_pulse_width = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     out_start_accepted;
  logic                     out_busy_res;
  logic                     out_finished_now;
  logic [prc_pkg::PW_W-1:0] out_stored_min;
  logic [prc_pkg::PW_W-1:0] out_stored_mid;
  logic [prc_pkg::PW_W-1:0] out_stored_max;

  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  int   items_sent  = 0;
  int   burst_left  = 0;
  logic steady      = 1'b0;
  logic hold_req    = 1'b0;

  pulse_range_calibrator_top dut (.*);

  prc_calib_checker checker_i (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[pulse_range_calibrator_top] ERROR");
      $finish;
    end
  end

  // Receiver: changes stall mode now and then; one long hold-off per request.
  initial begin : receiver
    int mode, mode_left, tick, hold_left;
    logic held;
    mode = 0;
    mode_left = 0;
    tick = 0;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (mode_left == 0) begin
        mode = $urandom_range(3, 0);
        mode_left = $urandom_range(200, 20);
      end
      mode_left--;
      if (hold_req && !held) begin
        hold_left = 64;
        held = 1'b1;
      end
      if (!hold_req) held = 1'b0;
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        case (mode)
          0:       out_ready = 1'b1;
          1:       out_ready = ($urandom_range(3, 0) != 0);
          2:       out_ready = ((tick % 7) < 3);
          default: out_ready = ($urandom_range(3, 0) == 0);
        endcase
      end
    end
  end

  task automatic send_item(input logic act, input logic [prc_pkg::CH_W-1:0] ch,
                           input int pw);
    if (!steady && burst_left == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(6, 0)) @(negedge clk);
      burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(60, 20)
                                               : $urandom_range(12, 1);
    end
    @(negedge clk);
    in_valid       = 1'b1;
    in_action      = act;
    in_channel     = ch;
    in_pulse_width = pw[prc_pkg::PW_W-1:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left > 0) burst_left--;
    items_sent++;
  endtask

  function automatic int clamp_pulse(input int v);
    return (v < 0) ? 0 : ((v > PW_MAX) ? PW_MAX : v);
  endfunction

  // One calibration pass: arm, center, excursions and wander, then return.
  task automatic calib_sweep(input int db);
    logic [prc_pkg::CH_W-1:0] ch;
    int centre, n, k, p, jit;
    ch = prc_pkg::CH_W'($urandom_range(prc_pkg::NUM_CHANNELS - 1, 0));
    centre = ($urandom_range(3, 0) == 0) ? $urandom_range(PW_MAX, 1)
                                         : $urandom_range(2200, 800);
    send_item(prc_pkg::ACT_START, ch, centre);
    send_item(prc_pkg::ACT_SAMPLE, ch, centre);
    n = $urandom_range(8, 2);
    for (k = 0; k < n; k++) begin
      case ($urandom_range(2, 0))
        0: begin
          jit = $urandom_range(400, 0);
          p = centre + db + 1 + jit;
        end
        1: begin
          jit = $urandom_range(400, 0);
          p = centre - db - 1 - jit;
        end
        default: begin
          jit = $urandom_range(2 * db, 0);
          p = centre + jit - db;
        end
      endcase
      send_item(prc_pkg::ACT_SAMPLE, ch, clamp_pulse(p));
    end
    p = centre;
    if (db > 0) begin
      jit = $urandom_range(2 * (db - 1), 0);
      p = centre + jit - (db - 1);
    end
    send_item(prc_pkg::ACT_SAMPLE, ch, clamp_pulse(p));
  endtask

  task automatic send_noise();
    int pw;
    case ($urandom_range(7, 0))
      0:       pw = 0;
      1:       pw = PW_MAX;
      default: pw = $urandom_range(PW_MAX, 0);
    endcase
    send_item(1'($urandom_range(1, 0)),
              prc_pkg::CH_W'($urandom_range(prc_pkg::NUM_CHANNELS - 1, 0)), pw);
  endtask

  task automatic random_mix(input int db, input int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(4, 0) != 0) calib_sweep(db);
      else send_noise();
    end
  endtask

  // Drop valid and drain every pending result before touching the register.
  task automatic quiesce();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_deadband(input int v);
    @(negedge clk);
    cfg_valid    = 1'b1;
    cfg_deadband = v[prc_pkg::PW_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin : stimulus
    int ph, db;
    logic [prc_pkg::CH_W-1:0] ch0, ch1;
    ch0 = prc_pkg::CH_W'(0);
    ch1 = prc_pkg::CH_W'(1);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part at the reset deadband.
    send_item(prc_pkg::ACT_SAMPLE, ch0, 1000);   // sample on an idle channel
    send_item(prc_pkg::ACT_START, ch0, 0);       // start with no signal
    send_item(prc_pkg::ACT_START, ch0, 1500);
    send_item(prc_pkg::ACT_SAMPLE, ch0, 1500);   // first sample sets min, mid, max
    send_item(prc_pkg::ACT_SAMPLE, ch0, 1600);
    send_item(prc_pkg::ACT_SAMPLE, ch0, 1540);   // back near mid, min not seen yet
    send_item(prc_pkg::ACT_SAMPLE, ch0, 1400);
    send_item(prc_pkg::ACT_SAMPLE, ch0, 1520);   // completes
    send_item(prc_pkg::ACT_SAMPLE, ch0, 1500);
    send_item(prc_pkg::ACT_START, ch1, PW_MAX);
    send_item(prc_pkg::ACT_START, ch1, 20);      // re-arm while in progress
    send_item(prc_pkg::ACT_SAMPLE, ch1, 20);     // mid below deadband
    send_item(prc_pkg::ACT_SAMPLE, ch1, 0);      // cannot lower min
    send_item(prc_pkg::ACT_SAMPLE, ch1, PW_MAX);
    send_item(prc_pkg::ACT_SAMPLE, ch1, 30);
    send_item(prc_pkg::ACT_START, ch1, 32768);
    send_item(prc_pkg::ACT_SAMPLE, ch1, 32768);
    send_item(prc_pkg::ACT_SAMPLE, ch1, PW_MAX);
    send_item(prc_pkg::ACT_SAMPLE, ch1, 0);
    send_item(prc_pkg::ACT_SAMPLE, ch1, 32767);
    send_item(prc_pkg::ACT_START, ch0, 1);
    send_item(prc_pkg::ACT_SAMPLE, ch0, PW_MAX);

    for (ph = 0; ph < 7; ph++) begin
      case (ph)
        0:       db = 0;
        1:       db = PW_MAX;
        2:       db = 1;
        3:       db = 50;
        4:       db = $urandom_range(600, 100);
        5:       db = 200;
        default: db = $urandom_range(PW_MAX, 0);
      endcase
      quiesce();
      write_deadband(db);
      if (ph == 3 || ph == 6) begin
        // fill the block while the receiver holds off
        @(posedge clk);
        steady   = 1'b1;
        hold_req = 1'b1;
        random_mix(db, 40);
        steady   = 1'b0;
        hold_req = 1'b0;
      end
      random_mix(db, PHASE_ITEMS);
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("[pulse_range_calibrator_top] OK");
    end else begin
      $display("[pulse_range_calibrator_top] ERROR");
    end
    $finish;
  end

endmodule
